[rtl/md5bc_pkg.sv]
`timescale 1ns / 1ps
// md5bc_pkg: types, codes and round tables for the md5 block compression core
// no dependencies; used by md5bc_if.sv and md5_block_compress.sv

package md5bc_pkg;

    typedef logic [31:0] t_word;

    // request function codes
    localparam logic [1:0] FUNC_LOAD_CHAIN = 2'd0;
    localparam logic [1:0] FUNC_LOAD_MSG   = 2'd1;
    localparam logic [1:0] FUNC_COMPRESS   = 2'd2;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_CHAIN  = 4;
    localparam int unsigned NUM_MSG    = 16;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] word_index;
        t_word      data_word;
    } t_in_req;

    typedef struct packed {
        t_word      digest_word;
        logic [1:0] digest_index;
        logic       last_word;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_ROT,
        S_FINAL,
        S_EMIT
    } t_state;

    // round mixing functions, one per group of sixteen rounds
    function automatic t_word mix(input logic [1:0] phase, input t_word x,
                                  input t_word y, input t_word z);
        t_word r;
        unique case (phase)
            2'd0: r = (x & y) | (~x & z);
            2'd1: r = (x & z) | (y & ~z);
            2'd2: r = x ^ y ^ z;
            2'd3: r = y ^ (x | ~z);
        endcase
        return r;
    endfunction

    // message word order: first + step * stride, mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] k);
        logic [3:0] first;
        logic [2:0] stride;
        logic [6:0] prod;
        unique case (k[5:4])
            2'd0: begin first = 4'd0; stride = 3'd1; end
            2'd1: begin first = 4'd1; stride = 3'd5; end
            2'd2: begin first = 4'd5; stride = 3'd3; end
            2'd3: begin first = 4'd0; stride = 3'd7; end
        endcase
        prod = k[3:0] * stride;
        return first + prod[3:0];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] k);
        logic [4:0] r;
        unique case ({k[5:4], k[1:0]})
            4'd0:  r = 5'd7;
            4'd1:  r = 5'd12;
            4'd2:  r = 5'd17;
            4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;
            4'd5:  r = 5'd9;
            4'd6:  r = 5'd14;
            4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;
            4'd9:  r = 5'd11;
            4'd10: r = 5'd16;
            4'd11: r = 5'd23;
            4'd12: r = 5'd6;
            4'd13: r = 5'd10;
            4'd14: r = 5'd15;
            4'd15: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic t_word rotl(input t_word v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction

    // floor(2^32 * |sin(k + 1)|)
    function automatic t_word add_const(input logic [5:0] k);
        t_word r;
        unique case (k)
            6'd0:  r = 32'hd76aa478;  6'd1:  r = 32'he8c7b756;
            6'd2:  r = 32'h242070db;  6'd3:  r = 32'hc1bdceee;
            6'd4:  r = 32'hf57c0faf;  6'd5:  r = 32'h4787c62a;
            6'd6:  r = 32'ha8304613;  6'd7:  r = 32'hfd469501;
            6'd8:  r = 32'h698098d8;  6'd9:  r = 32'h8b44f7af;
            6'd10: r = 32'hffff5bb1;  6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122;  6'd13: r = 32'hfd987193;
            6'd14: r = 32'ha679438e;  6'd15: r = 32'h49b40821;
            6'd16: r = 32'hf61e2562;  6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51;  6'd19: r = 32'he9b6c7aa;
            6'd20: r = 32'hd62f105d;  6'd21: r = 32'h02441453;
            6'd22: r = 32'hd8a1e681;  6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6;  6'd25: r = 32'hc33707d6;
            6'd26: r = 32'hf4d50d87;  6'd27: r = 32'h455a14ed;
            6'd28: r = 32'ha9e3e905;  6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9;  6'd31: r = 32'h8d2a4c8a;
            6'd32: r = 32'hfffa3942;  6'd33: r = 32'h8771f681;
            6'd34: r = 32'h6d9d6122;  6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44;  6'd37: r = 32'h4bdecfa9;
            6'd38: r = 32'hf6bb4b60;  6'd39: r = 32'hbebfbc70;
            6'd40: r = 32'h289b7ec6;  6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085;  6'd43: r = 32'h04881d05;
            6'd44: r = 32'hd9d4d039;  6'd45: r = 32'he6db99e5;
            6'd46: r = 32'h1fa27cf8;  6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244;  6'd49: r = 32'h432aff97;
            6'd50: r = 32'hab9423a7;  6'd51: r = 32'hfc93a039;
            6'd52: r = 32'h655b59c3;  6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d;  6'd55: r = 32'h85845dd1;
            6'd56: r = 32'h6fa87e4f;  6'd57: r = 32'hfe2ce6e0;
            6'd58: r = 32'ha3014314;  6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82;  6'd61: r = 32'hbd3af235;
            6'd62: r = 32'h2ad7d2bb;  6'd63: r = 32'heb86d391;
        endcase
        return r;
    endfunction

endpackage

[rtl/md5bc_if.sv]
`timescale 1ns / 1ps
// md5bc_in_if / md5bc_out_if: valid-ready channels for the md5 core
// depends on md5bc_pkg for the payload types

interface md5bc_in_if;
    logic                 valid;
    logic                 ready;
    md5bc_pkg::t_in_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface md5bc_out_if;
    logic                 valid;
    logic                 ready;
    md5bc_pkg::t_out_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/md5_block_compress.sv]
`timescale 1ns / 1ps
// md5_block_compress: one md5 compression over a stored 512-bit block
// depends on md5bc_pkg and the channel interfaces in md5bc_if.sv

// Load requests (chaining word or message word) are taken while idle. A compress
// request runs the 64 rounds on one shared round datapath, each round a four-operand
// sum (S_SUM), then rotate and add (S_ROT), then the chaining add (S_FINAL), then
// four result requests at up to one per cycle, as the sink accepts them. The input
// is not ready while a compress is running or its results are being emitted.
// Chaining and message words read before being written give undefined results.
module md5_block_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5bc_in_if.sink    i_req,
    md5bc_out_if.source o_rsp
);
    import md5bc_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [1:0] r_emit_cnt, n_emit_cnt;

    t_word r_chain [NUM_CHAIN];
    t_word r_msg   [NUM_MSG];
    t_word r_a, r_b, r_c, r_d;
    t_word r_sum;

    logic  in_acc, out_acc;
    logic  emit_last;
    t_word round_sum, new_b;

    assign in_acc    = i_req.valid & i_req.ready;
    assign out_acc   = o_rsp.valid & o_rsp.ready;
    assign emit_last = (r_emit_cnt == 2'd3);

    // shared round datapath
    assign round_sum = r_a + mix(r_round[5:4], r_b, r_c, r_d)
                     + r_msg[msg_index(r_round)] + add_const(r_round);
    assign new_b     = r_b + rotl(r_sum, rot_amount(r_round));

    // next state
    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_emit_cnt = r_emit_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req.data.func == FUNC_COMPRESS) begin
                    n_state = S_SUM;
                    n_round = '0;
                end
            end
            S_SUM: n_state = S_ROT;
            S_ROT: begin
                n_round = r_round + 6'd1;
                n_state = (r_round == 6'(NUM_ROUNDS - 1)) ? S_FINAL : S_SUM;
            end
            S_FINAL: begin
                n_state    = S_EMIT;
                n_emit_cnt = '0;
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_emit_cnt = r_emit_cnt + 2'd1;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready             = (r_state == S_IDLE);
        o_rsp.valid             = (r_state == S_EMIT);
        o_rsp.data.digest_word  = r_chain[r_emit_cnt];
        o_rsp.data.digest_index = r_emit_cnt;
        o_rsp.data.last_word    = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_round    <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req.data.func)
                        FUNC_LOAD_CHAIN: begin
                            if (i_req.data.word_index[3:2] == 2'd0) begin
                                r_chain[i_req.data.word_index[1:0]] <= i_req.data.data_word;
                            end
                        end
                        FUNC_LOAD_MSG: r_msg[i_req.data.word_index] <= i_req.data.data_word;
                        FUNC_COMPRESS: begin
                            r_a <= r_chain[0];
                            r_b <= r_chain[1];
                            r_c <= r_chain[2];
                            r_d <= r_chain[3];
                        end
                        default: ;
                    endcase
                end
            end
            S_SUM: r_sum <= round_sum;
            S_ROT: begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= new_b;
            end
            S_FINAL: begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            S_EMIT: ;
        endcase
    end

    // input and output sides are never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("input ready while results pending");

    a_compress_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.data.func == FUNC_COMPRESS) |=> (r_state == S_SUM && r_round == 6'd0))
        else $error("compress request did not start round zero");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_round == 6'(NUM_ROUNDS - 1)) |=> (r_state == S_FINAL))
        else $error("last round not followed by chaining add");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_rsp.data.last_word) |=> (r_state == S_IDLE))
        else $error("block not idle after last digest word");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for md5_block_compress, with its own md5 round model
// depends on md5bc_pkg, md5bc_if.sv and the md5_block_compress rtl

module tb_top;
    import md5bc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_FROM   = 60;
    localparam int QUIET_TO     = 160;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;

    localparam t_word SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // tracks chaining value and message block, queues the expected digest words
    class digest_tracker;
        t_word    chain [NUM_CHAIN];
        t_word    block [NUM_MSG];
        t_out_req digest_q [$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return digest_q.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function void run_rounds();
            t_word a, b, c, d, f, s;
            int    g, sh;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int k = 0; k < NUM_ROUNDS; k++) begin
                case (k / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = k;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * k + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * k + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * k) % 16;
                    end
                endcase
                sh = ROT_BY[(k / 16) * 4 + k % 4];
                s  = a + f + block[g] + SINE_K[k];
                s  = (s << sh) | (s >> (32 - sh));
                a  = d;
                d  = c;
                c  = b;
                b  = b + s;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_request(t_in_req r);
            t_out_req e;
            case (r.func)
                FUNC_LOAD_CHAIN: begin
                    if (r.word_index < NUM_CHAIN) chain[r.word_index[1:0]] = r.data_word;
                end
                FUNC_LOAD_MSG: block[r.word_index] = r.data_word;
                FUNC_COMPRESS: begin
                    run_rounds();
                    for (int i = 0; i < NUM_CHAIN; i++) begin
                        e.digest_word  = chain[i];
                        e.digest_index = i[1:0];
                        e.last_word    = (i == NUM_CHAIN - 1);
                        digest_q.push_back(e);
                    end
                end
                default: ;
            endcase
        endfunction

        task check_digest(t_out_req got);
            t_out_req want;
            if (digest_q.size() == 0) begin
                report($sformatf("unexpected word %h index %0d", got.digest_word,
                                 got.digest_index));
            end else begin
                want = digest_q.pop_front();
                if (got.digest_word !== want.digest_word)
                    report($sformatf("digest_word %h, want %h (index %0d)",
                                     got.digest_word, want.digest_word, want.digest_index));
                if (got.digest_index !== want.digest_index)
                    report($sformatf("digest_index %0d, want %0d", got.digest_index,
                                     want.digest_index));
                if (got.last_word !== want.last_word)
                    report($sformatf("last_word %b, want %b (index %0d)", got.last_word,
                                     want.last_word, want.digest_index));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet = 1'b0;
    logic rsp_hold = 1'b0;
    int   items_sent = 0;
    int   stall_cycles = 0;

    digest_tracker sb;

    md5bc_in_if  req_if();
    md5bc_out_if rsp_if();

    md5_block_compress dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sink side: random stalls, none while quiet, ready held low throughout the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || rsp_hold) begin
            rsp_if.ready <= 1'b0;
        end else if (quiet) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (req_if.valid === 1'b1 && req_if.ready === 1'b1) sb.note_request(req_if.data);
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) sb.check_digest(rsp_if.data);
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // long sink hold-off so the core stalls with results pending and stops taking requests
    initial begin
        wait (items_sent >= HOLD_AT);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_req(input logic [1:0] func, input logic [3:0] idx, input t_word word);
        t_in_req r;
        r.func       = func;
        r.word_index = idx;
        r.data_word  = word;
        while (!quiet && $urandom_range(99) < 20) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic random_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // ignored requests: unused func code, chaining index past the end
            if ($urandom_range(1)) send_req(FUNC_UNUSED, 4'($urandom_range(15)), $urandom);
            else send_req(FUNC_LOAD_CHAIN, 4'($urandom_range(15, NUM_CHAIN)), $urandom);
        end else begin
            if (pick < 24) begin
                send_req(FUNC_COMPRESS, 4'($urandom_range(15)), $urandom);
            end else if (pick < 55) begin
                send_req(FUNC_LOAD_CHAIN, 4'($urandom_range(NUM_CHAIN - 1)), $urandom);
            end else begin
                send_req(FUNC_LOAD_MSG, 4'($urandom_range(NUM_MSG - 1)), $urandom);
            end
        end
        items_sent++;
    endtask

    initial begin
        sb = new();
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full block with word extremes, then ignored requests, then a second compress
        send_req(FUNC_LOAD_CHAIN, 4'd0, 32'h0000_0000);
        send_req(FUNC_LOAD_CHAIN, 4'd1, 32'hffff_ffff);
        send_req(FUNC_LOAD_CHAIN, 4'd2, $urandom);
        send_req(FUNC_LOAD_CHAIN, 4'd3, $urandom);
        send_req(FUNC_LOAD_MSG, 4'd0, 32'hffff_ffff);
        for (int i = 1; i < NUM_MSG - 1; i++) send_req(FUNC_LOAD_MSG, i[3:0], $urandom);
        send_req(FUNC_LOAD_MSG, 4'd15, 32'h0000_0000);
        send_req(FUNC_COMPRESS, 4'd0, 32'h0000_0000);
        send_req(FUNC_UNUSED, 4'd15, 32'hffff_ffff);
        send_req(FUNC_LOAD_CHAIN, 4'd4, 32'hffff_ffff);
        send_req(FUNC_LOAD_CHAIN, 4'd15, 32'h0000_0000);
        send_req(FUNC_COMPRESS, 4'd15, 32'hffff_ffff);

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent == QUIET_FROM) quiet <= 1'b1;
            if (items_sent == QUIET_TO) quiet <= 1'b0;
            random_req();
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
